>>> rtl/tsam_pkg.sv
// ----------------------------------------------------------------------------
// tsam_pkg
// Shared types, widths and constants of the touch sample averaging block.
// ----------------------------------------------------------------------------
package tsam_pkg;

	// samples taken per axis in one cycle
	localparam int SAMPLES = 10;

	localparam int RAW_W   = 16;
	localparam int SAMPLE_W = 13;
	localparam int ACC_W   = 17;
	localparam int PHASE_W = $clog2(2 * SAMPLES);
	localparam int AVG_W   = 12;
	localparam int DIM_W   = 13;
	localparam int ROT_W   = 2;
	localparam int IDX_W   = 2;
	localparam int CFG_W   = 13;

	// divide by SAMPLES as multiply by a rounded-up reciprocal
	localparam int DIV_SHIFT = ACC_W + 5;
	localparam int RECIP_W   = DIV_SHIFT + 1;
	localparam logic [RECIP_W-1:0] DIV_RECIP =
		RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
	localparam int PROD_W = ACC_W + RECIP_W;
	localparam int QUO_W  = PROD_W - DIV_SHIFT;

	// scaling by panel size, 12 fraction bits
	localparam int FRAC_W  = 12;
	localparam int SCALE_W = AVG_W + DIM_W;

	localparam logic [AVG_W-1:0] FULL_SCALE = AVG_W'(4095);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [IDX_W-1:0] {
		REG_PANEL_WIDTH  = 2'd0,
		REG_PANEL_HEIGHT = 2'd1,
		REG_ROTATION     = 2'd2
	} reg_index_t;

	typedef enum logic [ROT_W-1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rotation_t;

	typedef struct packed {
		logic [DIM_W-1:0] panel_width;
		logic [DIM_W-1:0] panel_height;
		rotation_t        rotation;
	} cfg_t;

	// axis sums of one complete cycle
	typedef struct packed {
		logic [ACC_W-1:0] sum_x;
		logic [ACC_W-1:0] sum_y;
	} sums_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

>>> rtl/tsam_if.sv
// ----------------------------------------------------------------------------
// tsam_word_if / tsam_result_if
// Valid/ready channels for converter words and for averaged results.
// ----------------------------------------------------------------------------
interface tsam_word_if;
	logic        valid;
	logic        ready;
	logic [15:0] raw_word;

	modport source (output valid, output raw_word, input ready);
	modport sink   (input valid, input raw_word, output ready);
endinterface

interface tsam_result_if;
	logic        valid;
	logic        ready;
	logic        touched;
	logic [12:0] screen_x;
	logic [12:0] screen_y;
	logic [11:0] avg_x;
	logic [11:0] avg_y;

	modport source (output valid, output touched, output screen_x, output screen_y,
		output avg_x, output avg_y, input ready);
	modport sink   (input valid, input touched, input screen_x, input screen_y,
		input avg_x, input avg_y, output ready);
endinterface

>>> rtl/tsam_front.sv
// ----------------------------------------------------------------------------
// tsam_front
// Accepts converter words, accumulates each axis and hands finished sums on.
// ----------------------------------------------------------------------------
module tsam_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [tsam_pkg::RAW_W-1:0]   in_raw,
	output logic                         in_ready,
	input  logic                         q_full,
	output logic                         push,
	output tsam_pkg::sums_t              push_data
);
	import tsam_pkg::*;

	logic [PHASE_W-1:0]  phase_q;
	logic [ACC_W-1:0]    acc_q;
	logic [ACC_W-1:0]    sum_x_q;
	logic [SAMPLE_W-1:0] sample;
	logic [ACC_W-1:0]    sum;
	logic                accept;
	logic                last_x;
	logic                last_y;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign sample   = in_raw[RAW_W-1 -: SAMPLE_W];
	assign sum      = acc_q + ACC_W'(sample);
	assign last_x   = (phase_q == PHASE_W'(SAMPLES - 1));
	assign last_y   = (phase_q == PHASE_W'(2 * SAMPLES - 1));

	assign push            = accept && last_y;
	assign push_data.sum_x = sum_x_q;
	assign push_data.sum_y = sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			acc_q   <= '0;
			sum_x_q <= '0;
		end else if (accept) begin
			if (last_y) begin
				phase_q <= '0;
				acc_q   <= '0;
			end else if (last_x) begin
				phase_q <= phase_q + PHASE_W'(1);
				acc_q   <= '0;
				sum_x_q <= sum;
			end else begin
				phase_q <= phase_q + PHASE_W'(1);
				acc_q   <= sum;
			end
		end
	end

endmodule

>>> rtl/tsam_queue.sv
// ----------------------------------------------------------------------------
// tsam_queue
// Short queue of axis sums between the accumulating and mapping halves.
// ----------------------------------------------------------------------------
module tsam_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  tsam_pkg::sums_t         push_data,
	input  logic                    pop,
	output tsam_pkg::sums_t         head,
	output tsam_pkg::queue_status_t status
);
	import tsam_pkg::*;

	sums_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign head         = entry_q[rd_ptr_q];
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/tsam_back.sv
// ----------------------------------------------------------------------------
// tsam_back
// Divides the axis sums, clamps, scales to the panel and applies rotation.
// ----------------------------------------------------------------------------
module tsam_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tsam_pkg::cfg_t          cfg,
	input  tsam_pkg::queue_status_t q_status,
	input  tsam_pkg::sums_t         q_head,
	output logic                    pop,
	tsam_result_if.source           result
);
	import tsam_pkg::*;

	logic                valid_s1;
	logic [PROD_W-1:0]   prod_x_s1;
	logic [PROD_W-1:0]   prod_y_s1;

	logic                valid_s2;
	logic [SCALE_W-1:0]  scale_x_s2;
	logic [SCALE_W-1:0]  scale_y_s2;
	logic [AVG_W-1:0]    avg_x_s2;
	logic [AVG_W-1:0]    avg_y_s2;
	logic                touched_s2;

	logic                out_valid_q;
	logic                touched_q;
	logic [DIM_W-1:0]    screen_x_q;
	logic [DIM_W-1:0]    screen_y_q;
	logic [AVG_W-1:0]    avg_x_q;
	logic [AVG_W-1:0]    avg_y_q;

	logic                advance;
	logic [QUO_W-1:0]    quo_x;
	logic [QUO_W-1:0]    quo_y;
	logic [AVG_W-1:0]    ax;
	logic [AVG_W-1:0]    ay;
	logic [AVG_W-1:0]    cy;
	logic [DIM_W-1:0]    sx;
	logic [DIM_W-1:0]    sy;
	logic [DIM_W-1:0]    ox;
	logic [DIM_W-1:0]    oy;

	// whole pipe holds while a result waits
	assign advance = !out_valid_q || result.ready;
	assign pop     = advance && !q_status.empty;

	assign quo_x = prod_x_s1[DIV_SHIFT +: QUO_W];
	assign quo_y = prod_y_s1[DIV_SHIFT +: QUO_W];
	assign ax    = (quo_x > QUO_W'(FULL_SCALE)) ? FULL_SCALE : quo_x[AVG_W-1:0];
	assign cy    = (quo_y > QUO_W'(FULL_SCALE)) ? FULL_SCALE : quo_y[AVG_W-1:0];
	assign ay    = FULL_SCALE - cy;

	assign sx = scale_x_s2[FRAC_W +: DIM_W];
	assign sy = scale_y_s2[FRAC_W +: DIM_W];

	always_comb begin
		case (cfg.rotation)
			ROT_90: begin
				ox = sy;
				oy = cfg.panel_width - sx;
			end
			ROT_180: begin
				ox = cfg.panel_width - sx;
				oy = cfg.panel_height - sy;
			end
			ROT_270: begin
				ox = cfg.panel_height - sy;
				oy = sx;
			end
			default: begin
				ox = sx;
				oy = sy;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_x_s1  <= PROD_W'(q_head.sum_x) * PROD_W'(DIV_RECIP);
			prod_y_s1  <= PROD_W'(q_head.sum_y) * PROD_W'(DIV_RECIP);
			scale_x_s2 <= SCALE_W'(ax) * SCALE_W'(cfg.panel_width);
			scale_y_s2 <= SCALE_W'(ay) * SCALE_W'(cfg.panel_height);
			avg_x_s2   <= ax;
			avg_y_s2   <= ay;
			touched_s2 <= (ax != '0) && (ax != FULL_SCALE) &&
				(ay != '0) && (ay != FULL_SCALE);
			touched_q  <= touched_s2;
			screen_x_q <= ox;
			screen_y_q <= oy;
			avg_x_q    <= avg_x_s2;
			avg_y_q    <= avg_y_s2;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.touched  = touched_q;
	assign result.screen_x = screen_x_q;
	assign result.screen_y = screen_y_q;
	assign result.avg_x    = avg_x_q;
	assign result.avg_y    = avg_y_q;

endmodule

>>> rtl/touch_sample_average_map.sv
// ----------------------------------------------------------------------------
// touch_sample_average_map
// Averages resistive touch converter words and maps them to screen pixels.
// ----------------------------------------------------------------------------
// the block takes one raw 16-bit converter word per cycle on in_word while
// ready: SAMPLES words for x, then SAMPLES words for y, bits 15..3 of each
// being the sample. after every 2*SAMPLES accepted requests one result leaves
// on result via the queue, s1, s2 and output register. the input side never
// waits on the division or scaling: finished axis sums sit in a two-entry
// queue, so in_word only drops ready when two results are queued behind a
// result the sink has not taken. panel size and rotation are written on the
// cfg port and are read as a result is formed, so write them while idle.
// ----------------------------------------------------------------------------
module touch_sample_average_map (
	input  logic                       clk,
	input  logic                       arst_n,
	tsam_word_if.sink                  in_word,
	tsam_result_if.source              result,
	input  logic                       cfg_we,
	input  logic [tsam_pkg::IDX_W-1:0] cfg_index,
	input  logic [tsam_pkg::CFG_W-1:0] cfg_data
);
	import tsam_pkg::*;

	// configuration registers
	logic [DIM_W-1:0] panel_width_q;
	logic [DIM_W-1:0] panel_height_q;
	rotation_t        rotation_q;
	cfg_t             cfg;

	// front to queue to back
	logic          push;
	sums_t         push_data;
	logic          pop;
	sums_t         q_head;
	queue_status_t q_status;

	// register writes, an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q  <= DIM_W'(240);
			panel_height_q <= DIM_W'(320);
			rotation_q     <= ROT_0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_PANEL_WIDTH:  panel_width_q  <= cfg_data[DIM_W-1:0];
				REG_PANEL_HEIGHT: panel_height_q <= cfg_data[DIM_W-1:0];
				REG_ROTATION:     rotation_q     <= rotation_t'(cfg_data[ROT_W-1:0]);
				default:          ;
			endcase
		end
	end

	assign cfg.panel_width  = panel_width_q;
	assign cfg.panel_height = panel_height_q;
	assign cfg.rotation     = rotation_q;

	// accumulate words, one request a cycle while the queue is not full
	tsam_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_word.valid),
		.in_raw    (in_word.raw_word),
		.in_ready  (in_word.ready),
		.q_full    (q_status.full),
		.push      (push),
		.push_data (push_data)
	);

	// decouples the two halves
	tsam_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (q_head),
		.status    (q_status)
	);

	// divide, clamp, scale, rotate
	tsam_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_status (q_status),
		.q_head   (q_head),
		.pop      (pop),
		.result   (result)
	);

`ifndef SYNTHESIS
	// a full queue never takes another cycle of sums
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !push)
		else $error("push into full queue");

	// pop only from a non-empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.empty |-> !pop)
		else $error("pop from empty queue");

	// touched means both averages strictly inside the range
	a_touched_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.touched) |->
		(result.avg_x != '0 && result.avg_x != FULL_SCALE &&
		result.avg_y != '0 && result.avg_y != FULL_SCALE))
		else $error("touched with average at a limit");
`endif

endmodule

>>> sim/tb_touch_sample_average_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_sample_average_map
// Self-checking bench for the touch sample averaging and screen mapping block.
// Converter words go in over a valid/ready channel with random gaps, a local
// predictor works out each averaged and mapped result, and a sink process
// takes the results with random stalls and compares them field by field.
// ----------------------------------------------------------------------------
module tb_touch_sample_average_map;
	import tsam_pkg::*;

	// bench timing
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 400;
	localparam int MAX_GAP       = 16;
	localparam int RAND_PHASES   = 6;

	// index with no register behind it, written to check it is ignored
	localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct {
		logic             touched;
		logic [DIM_W-1:0] screen_x;
		logic [DIM_W-1:0] screen_y;
		logic [AVG_W-1:0] avg_x;
		logic [AVG_W-1:0] avg_y;
	} touch_report_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	tsam_word_if   word_ch ();
	tsam_result_if result_ch ();

	touch_sample_average_map i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (word_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// reports still owed by the block, oldest first
	touch_report_t pending_reports[$];

	int  mismatch_count;
	int  cycle_count;
	int  hold_left;
	bit  src_idle;
	bit  sink_idle;

	// local copy of the block state and its registers
	int               model_phase;
	logic [ACC_W-1:0] model_acc;
	logic [AVG_W-1:0] model_held_x;
	logic [DIM_W-1:0] cfg_width;
	logic [DIM_W-1:0] cfg_height;
	rotation_t        cfg_rot;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: a stuck handshake ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// sum over SAMPLES words, truncating divide, clamped to full scale
	function automatic logic [AVG_W-1:0] clamp_avg(logic [ACC_W-1:0] sum);
		int avg;
		avg = int'(sum) / SAMPLES;
		return (avg > int'(FULL_SCALE)) ? FULL_SCALE : AVG_W'(avg);
	endfunction

	// advance the local state by one accepted word; a finished y axis owes a report
	function automatic void predict_word(logic [RAW_W-1:0] raw);
		logic [AVG_W-1:0] ax;
		logic [AVG_W-1:0] ay;
		int               sx;
		int               sy;
		int               ox;
		int               oy;
		touch_report_t    rep;
		model_acc = model_acc + ACC_W'(raw[15:3]);
		model_phase++;
		if (model_phase == SAMPLES) begin
			model_held_x = clamp_avg(model_acc);
			model_acc = '0;
			return;
		end
		if (model_phase < 2 * SAMPLES)
			return;
		ax = model_held_x;
		ay = FULL_SCALE - clamp_avg(model_acc);
		model_phase = 0;
		model_acc = '0;
		// any axis at an end stop means no press
		rep.touched = (ax != 0) && (ax < FULL_SCALE) && (ay != 0) && (ay < FULL_SCALE);
		sx = (int'(ax) * int'(cfg_width)) >> 12;
		sy = (int'(ay) * int'(cfg_height)) >> 12;
		case (cfg_rot)
			ROT_90: begin
				ox = sy;
				oy = int'(cfg_width) - sx;
			end
			ROT_180: begin
				ox = int'(cfg_width) - sx;
				oy = int'(cfg_height) - sy;
			end
			ROT_270: begin
				ox = int'(cfg_height) - sy;
				oy = sx;
			end
			default: begin
				ox = sx;
				oy = sy;
			end
		endcase
		rep.screen_x = DIM_W'(ox);
		rep.screen_y = DIM_W'(oy);
		rep.avg_x = ax;
		rep.avg_y = ay;
		pending_reports.push_back(rep);
	endfunction

	// ------------------------------------------------------------------------
	// result side: random stalls, one long hold on request, field checks
	// ------------------------------------------------------------------------

	function automatic void compare_field(string what, logic [DIM_W-1:0] want,
			logic [DIM_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatch_count++;
		end
	endfunction

	initial begin : result_sink
		int            wait_left;
		touch_report_t want;
		wait_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				if (pending_reports.size() == 0) begin
					$display("%0t: result request, expected none, actual x %0d y %0d",
						$time, result_ch.avg_x, result_ch.avg_y);
					mismatch_count++;
				end else begin
					want = pending_reports.pop_front();
					compare_field("touched", DIM_W'(want.touched), DIM_W'(result_ch.touched));
					compare_field("screen_x", want.screen_x, result_ch.screen_x);
					compare_field("screen_y", want.screen_y, result_ch.screen_y);
					compare_field("avg_x", DIM_W'(want.avg_x), DIM_W'(result_ch.avg_x));
					compare_field("avg_y", DIM_W'(want.avg_y), DIM_W'(result_ch.avg_y));
				end
				wait_left = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
			end
			// the long hold is counted down here, with ready held low until it runs out
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (wait_left > 0) begin
				wait_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// input side helpers
	// ------------------------------------------------------------------------

	// offer one word, leaving valid high once it has been taken
	task automatic send_word(logic [RAW_W-1:0] raw);
		int gap;
		gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			word_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word_ch.valid <= 1'b1;
		word_ch.raw_word <= raw;
		@(posedge clk);
		while (word_ch.ready !== 1'b1)
			@(posedge clk);
		predict_word(raw);
	endtask

	// a 13-bit sample in the top bits, random junk in the low three
	function automatic logic [RAW_W-1:0] sample_word(int sample);
		int s;
		s = (sample < 0) ? 0 : (sample > 8191) ? 8191 : sample;
		return {SAMPLE_W'(s), 3'($urandom_range(0, 7))};
	endfunction

	// one full cycle: steady x samples then steady y samples
	task automatic send_point(int x_sample, int y_sample);
		repeat (SAMPLES) send_word(sample_word(x_sample));
		repeat (SAMPLES) send_word(sample_word(y_sample));
	endtask

	// stop offering, wait out every owed report and the block's tail
	task automatic wait_for_quiet();
		word_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PANEL_WIDTH:  cfg_width = val;
			REG_PANEL_HEIGHT: cfg_height = val;
			REG_ROTATION:     cfg_rot = rotation_t'(val[ROT_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic configure(int width, int height, rotation_t rot);
		wait_for_quiet();
		write_reg(REG_PANEL_WIDTH, CFG_W'(width));
		write_reg(REG_PANEL_HEIGHT, CFG_W'(height));
		write_reg(REG_ROTATION, CFG_W'(rot));
	endtask

	// panel sizes weighted toward the edges of the register
	function automatic int pick_size();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 1;
			2: return 4096;
			3: return 8191;
			default: return $urandom_range(1, 4096);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// one point under the reset panel size and rotation
	task automatic test_reset_config();
		send_point(1500, 2500);
	endtask

	// axes at and beyond the end stops, and just inside them
	task automatic test_extremes();
		send_point(0, 0);
		repeat (2 * SAMPLES) send_word(16'hFFFF);
		send_point(4095, 1);
		send_point(1, 4094);
		// average of exactly 4096 is clamped down
		send_point(4096, 4096);
	endtask

	// every rotation, zero panel size and the widest register values
	task automatic test_registers();
		configure(0, 0, ROT_180);
		send_point(2000, 2000);
		configure(8191, 8191, ROT_90);
		send_point(4000, 100);
		configure(4096, 1, ROT_270);
		send_point(1234, 3000);
		configure(1, 4096, ROT_0);
		send_point(3333, 777);
	endtask

	// writes landing part way through a cycle, one of them to no register
	task automatic test_midcycle_write();
		configure(240, 320, ROT_90);
		repeat (7) send_word(sample_word(900));
		wait_for_quiet();
		write_reg(REG_NONE, CFG_W'($urandom_range(0, 8191)));
		write_reg(REG_ROTATION, CFG_W'(ROT_270));
		write_reg(REG_PANEL_WIDTH, CFG_W'(800));
		repeat (SAMPLES - 7) send_word(sample_word(900));
		repeat (SAMPLES) send_word(sample_word(2100));
	endtask

	// sink holds off while words keep coming, so the queue fills and in_word stalls
	task automatic test_backpressure();
		configure(480, 272, ROT_0);
		src_idle = 1'b0;
		hold_left = HOLD_CYCLES;
		repeat (5) send_point($urandom_range(1, 4094), $urandom_range(1, 4094));
		wait_for_quiet();
		src_idle = 1'b1;
	endtask

	// mostly steady presses with jitter, some noise and end-stop words
	task automatic test_random();
		int word_total;
		int stroke_kind;
		int aim;
		logic [RAW_W-1:0] raw;
		stroke_kind = 0;
		aim = 0;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			configure(pick_size(), pick_size(), rotation_t'($urandom_range(0, 3)));
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_NONE, CFG_W'($urandom_range(0, 8191)));
			// some phases run flat out on one side or both
			src_idle = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			// phases may end part way through a cycle
			word_total = 3 * 2 * SAMPLES + $urandom_range(0, 2 * SAMPLES - 1);
			repeat (word_total) begin
				if (model_phase == 0 || model_phase == SAMPLES) begin
					stroke_kind = $urandom_range(0, 9);
					aim = $urandom_range(0, 4200);
				end
				if (stroke_kind < 7)
					raw = sample_word(aim + $urandom_range(0, 64) - 32);
				else if (stroke_kind < 9)
					raw = RAW_W'($urandom_range(0, 65535));
				else
					raw = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				send_word(raw);
			end
		end
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin : test_sequence
		mismatch_count = 0;
		cycle_count = 0;
		hold_left = 0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		model_phase = 0;
		model_acc = '0;
		model_held_x = '0;
		cfg_width = DIM_W'(240);
		cfg_height = DIM_W'(320);
		cfg_rot = ROT_0;

		arst_n <= 1'b0;
		word_ch.valid <= 1'b0;
		word_ch.raw_word <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PANEL_WIDTH;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_extremes();
		test_registers();
		test_midcycle_write();
		test_backpressure();
		test_random();

		wait_for_quiet();
		if (mismatch_count == 0 && pending_reports.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> files.f
rtl/tsam_pkg.sv
rtl/tsam_if.sv
rtl/tsam_front.sv
rtl/tsam_queue.sv
rtl/tsam_back.sv
rtl/touch_sample_average_map.sv
sim/tb_touch_sample_average_map.sv
